// ----- src/spp_pkg.sv -----
// ----------------------------------------------------------------------------
// spp_pkg
// Types, register indexes and the row-to-segment locator shared by the
// partial-refresh scheduler modules.
// ----------------------------------------------------------------------------
package spp_pkg;

	localparam int SPP_ROW_W = 16;
	localparam int SPP_PTR_W = 14;
	localparam int SPP_SEG_W = 2;   // up to four segments
	localparam int SPP_MAX_SEGS = 4;
	localparam int SPP_CFG_IDX_W = 3;
	localparam int SPP_CFG_DATA_W = 16;

	localparam logic [SPP_PTR_W-1:0] SPP_PTR_MAX = 14'h3FFF;

	// configuration register indexes
	localparam logic [SPP_CFG_IDX_W-1:0] SPP_REG_INTERVAL = 3'd0;
	localparam logic [SPP_CFG_IDX_W-1:0] SPP_REG_RANKS    = 3'd1;
	localparam logic [SPP_CFG_IDX_W-1:0] SPP_REG_ROW      = 3'd2;
	localparam logic [SPP_CFG_IDX_W-1:0] SPP_REG_PTR0     = 3'd3;
	localparam logic [SPP_CFG_IDX_W-1:0] SPP_REG_PTR1     = 3'd4;
	localparam logic [SPP_CFG_IDX_W-1:0] SPP_REG_PTR2     = 3'd5;
	localparam logic [SPP_CFG_IDX_W-1:0] SPP_REG_PTR3     = 3'd6;

	// input item
	typedef struct packed {
		logic                 action;       // 0 tick, 1 access
		logic [SPP_ROW_W-1:0] row_address;
	} spp_in_t;

	// result item
	typedef struct packed {
		logic                 refresh_issued;
		logic [3:0]           rank_mask;
		logic [SPP_ROW_W-1:0] refresh_row;
		logic                 pointer_raised;
	} spp_out_t;

	// classified item, front to back
	typedef struct packed {
		logic                 is_access;
		logic                 seg_valid;
		logic [SPP_SEG_W-1:0] seg_idx;
		logic [SPP_PTR_W-1:0] ptr_value;    // offset, saturated to pointer width
	} spp_cmd_t;

	// segment lookup of one row
	typedef struct packed {
		logic                 valid;
		logic [SPP_SEG_W-1:0] idx;
		logic [SPP_ROW_W-1:0] off;
	} spp_loc_t;

	// configuration write, top to back
	typedef struct packed {
		logic                      en;
		logic [SPP_CFG_IDX_W-1:0]  index;
		logic [SPP_CFG_DATA_W-1:0] data;
	} spp_cfg_wr_t;

	// Segment index and in-segment offset by compares against segment bounds.
	// seg_size and seg_count are elaboration constants at every call site.
	function automatic spp_loc_t spp_locate(input logic [SPP_ROW_W-1:0] row,
			input logic [16:0] seg_size, input logic [2:0] seg_count);
		spp_loc_t             loc;
		logic [18:0]          row_x;
		logic [18:0]          base;
		logic [SPP_SEG_W-1:0] idx;
		row_x = {3'b000, row};
		idx = '0;
		for (int k = 1; k < SPP_MAX_SEGS; k++) begin
			if (3'(k) < seg_count && row_x >= 19'(k) * {2'b00, seg_size}) begin
				idx = SPP_SEG_W'(k);
			end
		end
		base = {17'd0, idx} * {2'b00, seg_size};
		loc.valid = row_x < {16'd0, seg_count} * {2'b00, seg_size};
		loc.idx = idx;
		loc.off = SPP_ROW_W'(row_x - base);
		return loc;
	endfunction

endpackage

// ----- src/spp_front.sv -----
// ----------------------------------------------------------------------------
// spp_front
// Accepts input transactions and classifies them: finds the segment and
// saturated offset of an access before it is queued.
// ----------------------------------------------------------------------------
module spp_front #(
	parameter int ROW_COUNT = 65536,
	parameter int SEGMENT_COUNT = 4
) (
	input  logic             in_valid,
	output logic             in_stall,
	input  spp_pkg::spp_in_t in_item,
	input  logic             q_full,
	output logic             q_push,
	output spp_pkg::spp_cmd_t q_cmd
);
	import spp_pkg::*;

	localparam int SegRaw = ROW_COUNT / SEGMENT_COUNT;
	localparam int SegSize = (SegRaw == 0) ? 1 : SegRaw;

	spp_loc_t loc;

	assign in_stall = q_full;
	assign q_push = in_valid && !q_full;

	always_comb begin
		loc = spp_locate(in_item.row_address, 17'(SegSize), 3'(SEGMENT_COUNT));
		q_cmd.is_access = in_item.action;
		q_cmd.seg_valid = loc.valid;
		q_cmd.seg_idx = loc.idx;
		if (loc.off > {2'b00, SPP_PTR_MAX}) begin
			q_cmd.ptr_value = SPP_PTR_MAX;
		end else begin
			q_cmd.ptr_value = loc.off[SPP_PTR_W-1:0];
		end
	end

endmodule

// ----- src/spp_fifo.sv -----
// ----------------------------------------------------------------------------
// spp_fifo
// Two-entry queue of classified items between front and back.
// ----------------------------------------------------------------------------
module spp_fifo (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              push,
	input  spp_pkg::spp_cmd_t wr_cmd,
	output logic              full,
	input  logic              pop,
	output logic              rd_valid,
	output spp_pkg::spp_cmd_t rd_cmd
);
	import spp_pkg::*;

	localparam int Depth = 2;
	localparam int PtrW = $clog2(Depth);
	localparam int CntW = $clog2(Depth + 1);

	spp_cmd_t        mem_q [Depth];
	logic [PtrW-1:0] wr_ptr_q;
	logic [PtrW-1:0] rd_ptr_q;
	logic [CntW-1:0] count_q;

	assign full = count_q == CntW'(Depth);
	assign rd_valid = count_q != '0;
	assign rd_cmd = mem_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= wr_cmd;
		end
	end

endmodule

// ----- src/spp_back.sv -----
// ----------------------------------------------------------------------------
// spp_back
// Holds the scheduler state and configuration, carries out queued items and
// keeps the result in an output register.
// ----------------------------------------------------------------------------
module spp_back #(
	parameter int ROW_COUNT = 65536,
	parameter int SEGMENT_COUNT = 4
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  spp_pkg::spp_cfg_wr_t cfg_wr,
	input  logic                 q_valid,
	input  spp_pkg::spp_cmd_t    q_cmd,
	output logic                 q_pop,
	output logic                 out_valid,
	input  logic                 out_stall,
	output spp_pkg::spp_out_t    out_result
);
	import spp_pkg::*;

	localparam int SegRaw = ROW_COUNT / SEGMENT_COUNT;
	localparam int SegSize = (SegRaw == 0) ? 1 : SegRaw;
	localparam logic [SPP_ROW_W:0] Rows = (SPP_ROW_W+1)'(ROW_COUNT);

	logic [15:0]          interval_q;
	logic [2:0]           rank_count_q;
	logic [15:0]          tick_q;
	logic [SPP_ROW_W-1:0] row_q;
	logic [SPP_PTR_W-1:0] ptr_q [SPP_MAX_SEGS];
	logic                 out_valid_q;
	spp_out_t             out_result_q;

	spp_loc_t             loc;
	logic [3:0]           mask;
	logic [16:0]          tick_next;
	logic                 expire;
	logic [SPP_ROW_W:0]   row_adv;
	logic [SPP_ROW_W-1:0] row_next;
	logic                 hit;
	logic                 raise;
	logic [SPP_SEG_W-1:0] wr_seg;

	assign q_pop = q_valid && (!out_valid_q || !out_stall);
	assign out_valid = out_valid_q;
	assign out_result = out_result_q;

	always_comb begin
		// all-bank mask, saturated at four ranks
		case (rank_count_q)
			3'd0:    mask = 4'b0000;
			3'd1:    mask = 4'b0001;
			3'd2:    mask = 4'b0011;
			3'd3:    mask = 4'b0111;
			default: mask = 4'b1111;
		endcase
		tick_next = {1'b0, tick_q} + 17'd1;
		expire = tick_next >= {1'b0, interval_q};   // zero interval acts as one
		row_adv = expire ? ({1'b0, row_q} + 17'd1) : {1'b0, row_q};
		row_next = (row_adv >= Rows) ? '0 : row_adv[SPP_ROW_W-1:0];
		loc = spp_locate(row_q, 17'(SegSize), 3'(SEGMENT_COUNT));
		hit = expire && loc.valid && (loc.off <= {2'b00, ptr_q[loc.idx]}) &&
			(mask != 4'b0000);
		raise = q_cmd.seg_valid && (q_cmd.ptr_value > ptr_q[q_cmd.seg_idx]);
		wr_seg = SPP_SEG_W'(cfg_wr.index - SPP_REG_PTR0);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			interval_q <= 16'd6240;
			rank_count_q <= 3'd1;
			tick_q <= '0;
			row_q <= '0;
			for (int k = 0; k < SPP_MAX_SEGS; k++) begin
				ptr_q[k] <= '0;
			end
			out_valid_q <= 1'b0;
		end else begin
			if (cfg_wr.en) begin
				case (cfg_wr.index)
					SPP_REG_INTERVAL: interval_q <= cfg_wr.data;
					SPP_REG_RANKS:    rank_count_q <= cfg_wr.data[2:0];
					SPP_REG_ROW:      row_q <= cfg_wr.data;
					SPP_REG_PTR0, SPP_REG_PTR1, SPP_REG_PTR2, SPP_REG_PTR3: begin
						ptr_q[wr_seg] <= cfg_wr.data[SPP_PTR_W-1:0];
					end
					default: ;
				endcase
			end else if (q_pop) begin
				if (q_cmd.is_access) begin
					if (raise) begin
						ptr_q[q_cmd.seg_idx] <= q_cmd.ptr_value;
					end
				end else begin
					tick_q <= expire ? '0 : tick_next[15:0];
					row_q <= row_next;
				end
			end
			if (q_pop) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (q_pop) begin
			if (q_cmd.is_access) begin
				out_result_q.refresh_issued <= 1'b0;
				out_result_q.rank_mask <= 4'b0000;
				out_result_q.refresh_row <= row_q;
				out_result_q.pointer_raised <= raise;
			end else begin
				out_result_q.refresh_issued <= hit;
				out_result_q.rank_mask <= hit ? mask : 4'b0000;
				out_result_q.refresh_row <= row_next;
				out_result_q.pointer_raised <= 1'b0;
			end
		end
	end

endmodule

// ----- src/segment_pointer_partial_refresh.sv -----
// ----------------------------------------------------------------------------
// segment_pointer_partial_refresh
// DRAM partial-refresh scheduler with per-segment high-water pointers.
// ----------------------------------------------------------------------------
// One input transaction (tick or access) gives exactly one result transaction.
// The block takes one transaction per clock while in_stall is low; a result
// reaches out_valid via a queue entry and the output register. A front stage
// classifies each item (segment and offset of an access) and pushes it into a
// two-entry queue; the back stage updates the tick counter, refresh row
// counter and segment pointers, one item per cycle when not stalled, into a
// single output register. in_stall rises only once the queue has filled
// behind a stalled output register. Configuration writes are always ready and
// also load the refresh row counter or a segment pointer; they are meant to be
// issued while no transaction is in flight. No clearing pass after reset.
module segment_pointer_partial_refresh #(
	parameter int ROW_COUNT = 65536,    // rows in the refresh space, 4..65536
	parameter int SEGMENT_COUNT = 4     // segments with own pointer, 1..4
) (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 in_valid,
	output logic                                 in_stall,
	input  spp_pkg::spp_in_t                     in_item,
	output logic                                 out_valid,
	input  logic                                 out_stall,
	output spp_pkg::spp_out_t                    out_result,
	input  logic                                 cfg_valid,
	output logic                                 cfg_ready,
	input  logic [spp_pkg::SPP_CFG_IDX_W-1:0]    cfg_index,
	input  logic [spp_pkg::SPP_CFG_DATA_W-1:0]   cfg_data
);
	import spp_pkg::*;

	logic        q_push;
	logic        q_full;
	logic        q_pop;
	logic        q_valid;
	spp_cmd_t    push_cmd;
	spp_cmd_t    pop_cmd;
	spp_cfg_wr_t cfg_wr;

	// register writes complete in the cycle they are presented
	assign cfg_ready = 1'b1;
	assign cfg_wr.en = cfg_valid && cfg_ready;
	assign cfg_wr.index = cfg_index;
	assign cfg_wr.data = cfg_data;

	// front: accept and classify
	spp_front #(
		.ROW_COUNT     (ROW_COUNT),
		.SEGMENT_COUNT (SEGMENT_COUNT)
	) u_front (
		.in_valid (in_valid),
		.in_stall (in_stall),
		.in_item  (in_item),
		.q_full   (q_full),
		.q_push   (q_push),
		.q_cmd    (push_cmd)
	);

	// queue decouples input acceptance from result back-pressure
	spp_fifo u_fifo (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (q_push),
		.wr_cmd   (push_cmd),
		.full     (q_full),
		.pop      (q_pop),
		.rd_valid (q_valid),
		.rd_cmd   (pop_cmd)
	);

	// back: state update and result register
	spp_back #(
		.ROW_COUNT     (ROW_COUNT),
		.SEGMENT_COUNT (SEGMENT_COUNT)
	) u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_wr     (cfg_wr),
		.q_valid    (q_valid),
		.q_cmd      (pop_cmd),
		.q_pop      (q_pop),
		.out_valid  (out_valid),
		.out_stall  (out_stall),
		.out_result (out_result)
	);

endmodule

// ----- src/spp_checker.sv -----
// ----------------------------------------------------------------------------
// spp_checker
// Port-level checks of the partial-refresh scheduler, bound to the top level.
// ----------------------------------------------------------------------------
module spp_checker (
	input logic                               clk,
	input logic                               arst_n,
	input logic                               in_valid,
	input logic                               in_stall,
	input spp_pkg::spp_in_t                   in_item,
	input logic                               out_valid,
	input logic                               out_stall,
	input spp_pkg::spp_out_t                  out_result,
	input logic                               cfg_valid,
	input logic                               cfg_ready,
	input logic [spp_pkg::SPP_CFG_IDX_W-1:0]  cfg_index,
	input logic [spp_pkg::SPP_CFG_DATA_W-1:0] cfg_data
);
	import spp_pkg::*;

	// a stalled result holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(out_result))
		else $error("result changed while stalled");

	// input back-pressure only builds behind a stalled result
	a_stall_cause: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(in_stall) |-> $past(out_valid && out_stall))
		else $error("in_stall rose without output back-pressure");

	a_stall_full: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |-> out_valid)
		else $error("input stalled with empty output register");

	// a new result after idle comes from an accepted transaction that passed the queue and the output register
	a_latency: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) |-> $past(in_valid && !in_stall, 2))
		else $error("result appeared without matching input");

	a_mask: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> out_result.refresh_issued == (out_result.rank_mask != 4'd0))
		else $error("refresh flag and rank mask disagree");

endmodule

bind segment_pointer_partial_refresh spp_checker u_spp_checker (.*);
